// ===== hdl/bcc_pkg.sv =====
package bcc_pkg;

    // Datapath widths
    localparam int DATA_W     = 32;
    localparam int MUL_B_W    = 11;
    localparam int PROD_W     = 43;
    localparam int SAT_W      = 44;
    localparam int DIV_W      = PROD_W - 1;
    localparam int DVSR_W     = 20;
    localparam int DIV_STEPS  = 2;

    // Field widths
    localparam int SHUNT_W    = 20;
    localparam int BUS_W      = 15;
    localparam int AH_W       = 10;
    localparam int UV_W       = 21;
    localparam int MAS_W      = 22;

    // Register widths
    localparam int RSH_W      = 20;
    localparam int OFS_W      = 11;
    localparam int CSC_W      = 10;
    localparam int VSC_W      = 11;
    localparam int WC_W       = 10;
    localparam int EFF_W      = 7;
    localparam int CAP_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RSH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CSC = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VSC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WC  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EFF = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP = 3'd6;

    // Register reset values
    localparam int RSH_RST_INT = 750;
    localparam int OFS_RST_INT = -10;
    localparam int CSC_RST_INT = 100;
    localparam int VSC_RST_INT = 1000;
    localparam int WC_RST_INT  = 0;
    localparam int EFF_RST_INT = 75;
    localparam int CAP_RST_INT = 90;

    // Scale constants
    localparam int MILLI_INT      = 1000;
    localparam int PCT_INT        = 100;
    localparam int MAS_PER_AH_INT = 3600000;
    localparam logic [MAS_W-1:0] MAS_PER_AH = MAS_W'(MAS_PER_AH_INT);
    localparam logic signed [DATA_W-1:0] CHARGE_RST = DATA_W'(CAP_RST_INT * MAS_PER_AH_INT);
    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam int SPW_DEFAULT = 20;

    typedef struct packed {
        logic        [RSH_W-1:0] rsh;
        logic signed [OFS_W-1:0] ofs;
        logic        [CSC_W-1:0] csc;
        logic        [VSC_W-1:0] vsc;
        logic        [WC_W-1:0]  wc;
        logic        [EFF_W-1:0] eff;
        logic        [CAP_W-1:0] cap;
    } cfg_t;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-DATA_W:0] top;
        top = v[SAT_W-1:DATA_W-1];
        if ((&top) || !(|top)) begin
            return v[DATA_W-1:0];
        end else if (v[SAT_W-1]) begin
            return DATA_MIN;
        end else begin
            return DATA_MAX;
        end
    endfunction

endpackage

// ===== hdl/battery_coulomb_counter.sv =====
// A load command sets the charge counter directly; a measurement sample runs five
// multiply-divide steps, and a sample that closes a window with valid samples four more,
// all on one shared divider (2 quotient bits a cycle). One word at a time: s_ready returns
// with m_valid, so no new word is taken until the last result is loaded into the output
// register. Reset restores register defaults, clears window and averages, and sets the
// charge counter to 324000000 mAs.
module battery_coulomb_counter #(
    parameter int SAMPLES_PER_WINDOW = bcc_pkg::SPW_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic signed [bcc_pkg::SHUNT_W-1:0] s_shunt_uv,
    input  logic        [bcc_pkg::BUS_W-1:0]   s_bus_mv,
    input  logic                               s_sample_valid,
    input  logic        [bcc_pkg::AH_W-1:0]    s_charge_ah,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bcc_pkg::DATA_W-1:0]  m_current_ma,
    output logic                               m_window_done,
    output logic signed [bcc_pkg::DATA_W-1:0]  m_avg_shunt_uv,
    output logic signed [bcc_pkg::DATA_W-1:0]  m_avg_bus_mv,
    output logic signed [bcc_pkg::DATA_W-1:0]  m_avg_current_ma,
    output logic signed [bcc_pkg::DATA_W-1:0]  m_charge_mas
);
    import bcc_pkg::*;

    localparam int POS_W = $clog2(SAMPLES_PER_WINDOW + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // Multiply-divide steps
    localparam logic [3:0] OP_MA0  = 4'd0;
    localparam logic [3:0] OP_MA   = 4'd1;
    localparam logic [3:0] OP_MV   = 4'd2;
    localparam logic [3:0] OP_WIRE = 4'd3;
    localparam logic [3:0] OP_CRED = 4'd4;
    localparam logic [3:0] OP_AVG0 = 4'd5;
    localparam logic [3:0] OP_AVG1 = 4'd6;
    localparam logic [3:0] OP_AVG2 = 4'd7;
    localparam logic [3:0] OP_CHG  = 4'd8;

    cfg_t cfg;

    logic [2:0] state_reg;
    logic [3:0] op_reg;

    logic                      cmd_reg;
    logic [BUS_W-1:0]          bus_reg;
    logic                      svalid_reg;
    logic [AH_W-1:0]           ah_reg;
    logic signed [UV_W-1:0]    uv_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [DATA_W-1:0]  ma_reg;
    logic signed [DATA_W-1:0]  mv_reg;
    logic signed [DATA_W-1:0]  cred_reg;

    logic [POS_W-1:0]          pos_reg;
    logic [POS_W-1:0]          cnt_reg;
    logic signed [DATA_W-1:0]  sum_shunt_reg;
    logic signed [DATA_W-1:0]  sum_bus_reg;
    logic signed [DATA_W-1:0]  sum_cur_reg;
    logic signed [DATA_W-1:0]  sum_cred_reg;
    logic signed [DATA_W-1:0]  latest_reg;
    logic signed [DATA_W-1:0]  avg_shunt_reg;
    logic signed [DATA_W-1:0]  avg_bus_reg;
    logic signed [DATA_W-1:0]  avg_cur_reg;
    logic signed [DATA_W-1:0]  charge_reg;
    logic                      done_reg;
    logic                      m_valid_reg;

    logic signed [DATA_W-1:0]  m_current_reg;
    logic                      m_done_reg;
    logic signed [DATA_W-1:0]  m_avg_shunt_reg;
    logic signed [DATA_W-1:0]  m_avg_bus_reg;
    logic signed [DATA_W-1:0]  m_avg_cur_reg;
    logic signed [DATA_W-1:0]  m_charge_reg;

    logic signed [DATA_W-1:0]       mul_a;
    logic        [MUL_B_W-1:0]      mul_b;
    logic signed [DATA_W+MUL_B_W:0] mul_full;
    logic        [DVSR_W-1:0]       div_dvsr;
    logic                           div_start;
    logic                           div_done;
    logic signed [PROD_W-1:0]       div_quot;
    logic signed [SAT_W-1:0]        q_ext;

    logic                  accept;
    logic                  out_free;
    logic [POS_W-1:0]      pos_inc;
    logic [POS_W-1:0]      cnt_inc;
    logic [DATA_W-1:0]     cap_mas;
    logic [DATA_W-1:0]     load_mas;
    logic                  charge_lt_cap;

    bcc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_wdata),
        .cfg      (cfg)
    );

    bcc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (div_dvsr),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign div_start = (state_reg == S_START);
    assign q_ext     = SAT_W'(div_quot);
    assign pos_inc   = pos_reg + 1'b1;
    assign cnt_inc   = cnt_reg + POS_W'(svalid_reg);

    // Capacity cap and charge load value, both below 2^32
    assign cap_mas       = DATA_W'(cfg.cap) * DATA_W'(MAS_PER_AH);
    assign load_mas      = DATA_W'(ah_reg) * DATA_W'(MAS_PER_AH);
    assign charge_lt_cap = $signed({charge_reg[DATA_W-1], charge_reg}) <
                           $signed({1'b0, cap_mas});

    // Select multiplier operands for the current step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            OP_MA0: begin
                mul_a = DATA_W'(uv_reg);
                mul_b = MUL_B_W'(MILLI_INT);
            end
            OP_MA: begin
                mul_a = ma_reg;
                mul_b = MUL_B_W'(cfg.csc);
            end
            OP_MV: begin
                mul_a = DATA_W'(bus_reg);
                mul_b = cfg.vsc;
            end
            OP_WIRE: begin
                mul_a = ma_reg;
                mul_b = MUL_B_W'(cfg.wc);
            end
            OP_CRED: begin
                mul_a = ma_reg;
                mul_b = MUL_B_W'(cfg.eff);
            end
            OP_AVG0: begin
                mul_a = sum_shunt_reg;
                mul_b = MUL_B_W'(1);
            end
            OP_AVG1: begin
                mul_a = sum_bus_reg;
                mul_b = MUL_B_W'(1);
            end
            OP_AVG2: begin
                mul_a = sum_cur_reg;
                mul_b = MUL_B_W'(1);
            end
            OP_CHG: begin
                mul_a = sum_cred_reg;
                mul_b = MUL_B_W'(1);
            end
            default: ;
        endcase
    end

    assign mul_full = mul_a * $signed({1'b0, mul_b});

    // Select divisor for the current step
    always_comb begin
        case (op_reg)
            OP_MA0:                  div_dvsr = (cfg.rsh == '0) ? DVSR_W'(1) : cfg.rsh;
            OP_MA, OP_CRED:          div_dvsr = DVSR_W'(PCT_INT);
            OP_MV, OP_WIRE:          div_dvsr = DVSR_W'(MILLI_INT);
            OP_AVG0, OP_AVG1,
            OP_AVG2, OP_CHG:         div_dvsr = DVSR_W'(cnt_reg);
            default:                 div_dvsr = DVSR_W'(1);
        endcase
    end

    // Sequencer and block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_MA0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            sum_shunt_reg <= '0;
            sum_bus_reg   <= '0;
            sum_cur_reg   <= '0;
            sum_cred_reg  <= '0;
            latest_reg    <= '0;
            avg_shunt_reg <= '0;
            avg_bus_reg   <= '0;
            avg_cur_reg   <= '0;
            charge_reg    <= CHARGE_RST;
            done_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // Raise valid as a word is loaded, drop it once taken
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    done_reg <= 1'b0;
                    if (cmd_reg) begin
                        charge_reg <= load_mas[DATA_W-1] ? DATA_MAX : load_mas;
                        state_reg  <= S_OUT;
                    end else begin
                        op_reg    <= OP_MA0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    state_reg <= S_START;
                end
                S_START: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_done) begin
                        case (op_reg)
                            OP_MA0: begin
                                op_reg    <= OP_MA;
                                state_reg <= S_MUL;
                            end
                            OP_MA: begin
                                op_reg    <= OP_MV;
                                state_reg <= S_MUL;
                            end
                            OP_MV: begin
                                op_reg    <= OP_WIRE;
                                state_reg <= S_MUL;
                            end
                            OP_WIRE: begin
                                op_reg    <= OP_CRED;
                                state_reg <= S_MUL;
                            end
                            OP_CRED: begin
                                state_reg <= S_ACC;
                            end
                            OP_AVG0: begin
                                avg_shunt_reg <= sat32(q_ext);
                                op_reg        <= OP_AVG1;
                                state_reg     <= S_MUL;
                            end
                            OP_AVG1: begin
                                avg_bus_reg <= sat32(q_ext);
                                op_reg      <= OP_AVG2;
                                state_reg   <= S_MUL;
                            end
                            OP_AVG2: begin
                                avg_cur_reg <= sat32(q_ext);
                                op_reg      <= OP_CHG;
                                state_reg   <= S_MUL;
                            end
                            OP_CHG: begin
                                if (charge_lt_cap || sum_cred_reg[DATA_W-1]) begin
                                    charge_reg <= sat32(SAT_W'(charge_reg) + q_ext);
                                end
                                done_reg      <= 1'b1;
                                pos_reg       <= '0;
                                cnt_reg       <= '0;
                                sum_shunt_reg <= '0;
                                sum_bus_reg   <= '0;
                                sum_cur_reg   <= '0;
                                sum_cred_reg  <= '0;
                                state_reg     <= S_OUT;
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_ACC: begin
                    // Fold the sample into the window, then close it when full
                    if (svalid_reg) begin
                        sum_shunt_reg <= sat32(SAT_W'(sum_shunt_reg) + SAT_W'(uv_reg));
                        sum_bus_reg   <= sat32(SAT_W'(sum_bus_reg) + SAT_W'(mv_reg));
                        sum_cur_reg   <= sat32(SAT_W'(sum_cur_reg) + SAT_W'(ma_reg));
                        sum_cred_reg  <= sat32(SAT_W'(sum_cred_reg) + SAT_W'(cred_reg));
                        latest_reg    <= ma_reg;
                    end
                    if (pos_inc >= POS_W'(SAMPLES_PER_WINDOW)) begin
                        if (cnt_inc != '0) begin
                            pos_reg   <= pos_inc;
                            cnt_reg   <= cnt_inc;
                            op_reg    <= OP_AVG0;
                            state_reg <= S_MUL;
                        end else begin
                            pos_reg       <= '0;
                            cnt_reg       <= '0;
                            sum_shunt_reg <= '0;
                            sum_bus_reg   <= '0;
                            sum_cur_reg   <= '0;
                            sum_cred_reg  <= '0;
                            state_reg     <= S_OUT;
                        end
                    end else begin
                        pos_reg   <= pos_inc;
                        cnt_reg   <= cnt_inc;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= s_command;
            bus_reg    <= s_bus_mv;
            svalid_reg <= s_sample_valid;
            ah_reg     <= s_charge_ah;
            uv_reg     <= UV_W'(s_shunt_uv) - UV_W'($signed(cfg.ofs));
        end
        if (state_reg == S_MUL) begin
            prod_reg <= mul_full[PROD_W-1:0];
        end
        if (state_reg == S_WAIT && div_done) begin
            case (op_reg)
                OP_MA0, OP_MA: ma_reg <= sat32(q_ext);
                OP_MV:         mv_reg <= sat32(q_ext);
                OP_WIRE:       mv_reg <= sat32(SAT_W'(mv_reg) - q_ext);
                OP_CRED:       cred_reg <= ma_reg[DATA_W-1] ? ma_reg : sat32(q_ext);
                default: ;
            endcase
        end
        // Load the result word once the output register is free
        if (state_reg == S_OUT && out_free) begin
            m_current_reg   <= latest_reg;
            m_done_reg      <= done_reg;
            m_avg_shunt_reg <= avg_shunt_reg;
            m_avg_bus_reg   <= avg_bus_reg;
            m_avg_cur_reg   <= avg_cur_reg;
            m_charge_reg    <= charge_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_current_ma     = m_current_reg;
    assign m_window_done    = m_done_reg;
    assign m_avg_shunt_uv   = m_avg_shunt_reg;
    assign m_avg_bus_mv     = m_avg_bus_reg;
    assign m_avg_current_ma = m_avg_cur_reg;
    assign m_charge_mas     = m_charge_reg;

endmodule

// ===== hdl/bcc_cfg.sv =====
module bcc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]  wr_data,
    output bcc_pkg::cfg_t                   cfg
);
    import bcc_pkg::*;

    cfg_t cfg_reg;

    // Write one register per enabled cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rsh <= RSH_W'(RSH_RST_INT);
            cfg_reg.ofs <= OFS_W'(OFS_RST_INT);
            cfg_reg.csc <= CSC_W'(CSC_RST_INT);
            cfg_reg.vsc <= VSC_W'(VSC_RST_INT);
            cfg_reg.wc  <= WC_W'(WC_RST_INT);
            cfg_reg.eff <= EFF_W'(EFF_RST_INT);
            cfg_reg.cap <= CAP_W'(CAP_RST_INT);
        end else if (wr_en) begin
            case (wr_index)
                CFG_RSH: cfg_reg.rsh <= wr_data[RSH_W-1:0];
                CFG_OFS: cfg_reg.ofs <= wr_data[OFS_W-1:0];
                CFG_CSC: cfg_reg.csc <= wr_data[CSC_W-1:0];
                CFG_VSC: cfg_reg.vsc <= wr_data[VSC_W-1:0];
                CFG_WC:  cfg_reg.wc  <= wr_data[WC_W-1:0];
                CFG_EFF: cfg_reg.eff <= wr_data[EFF_W-1:0];
                CFG_CAP: cfg_reg.cap <= wr_data[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/bcc_div.sv =====
module bcc_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [bcc_pkg::PROD_W-1:0]  dividend,
    input  logic        [bcc_pkg::DVSR_W-1:0]  divisor,
    output logic                               done,
    output logic signed [bcc_pkg::PROD_W-1:0]  quotient
);
    import bcc_pkg::*;

    localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
    localparam int CNT_W      = $clog2(DIV_CYCLES);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 neg_reg;
    logic [DVSR_W-1:0]    dvsr_reg;
    logic [DVSR_W-1:0]    rem_reg;
    logic [DVSR_W-1:0]    rem_next;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     quo_next;
    logic [PROD_W-1:0]    mag_in;
    logic signed [PROD_W-1:0] mag_out;

    // Two restoring steps per cycle
    always_comb begin
        logic [DVSR_W:0]   sh;
        logic [DVSR_W-1:0] r;
        logic [DIV_W-1:0]  q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < DIV_STEPS; i++) begin
            sh = {r, q[DIV_W-1]};
            q  = {q[DIV_W-2:0], 1'b0};
            if (sh >= {1'b0, dvsr_reg}) begin
                sh   = sh - {1'b0, dvsr_reg};
                q[0] = 1'b1;
            end
            r = sh[DVSR_W-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    assign mag_in = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);

    // Sequence control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_CYCLES - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg  <= dividend[PROD_W-1];
            dvsr_reg <= divisor;
            rem_reg  <= '0;
            quo_reg  <= mag_in[DIV_W-1:0];
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Restore sign, truncating toward zero
    assign mag_out  = {1'b0, quo_reg};
    assign quotient = neg_reg ? -mag_out : mag_out;
    assign done     = done_reg;

endmodule

// ===== hdl/bcc_check.sv =====
module bcc_check (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [bcc_pkg::DATA_W-1:0] m_current_ma,
    input logic                              m_window_done,
    input logic signed [bcc_pkg::DATA_W-1:0] m_charge_mas
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_current_ma) &&
        $stable(m_window_done) && $stable(m_charge_mas))
        else $error("result word changed while stalled");

    // Drop ready for the cycle after a word is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // Come out of reset idle with no result pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

    // A new result only follows a busy cycle
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without work");

endmodule

bind battery_coulomb_counter bcc_check u_bcc_check (.*);

// ===== tb/battery_coulomb_counter_tb.sv =====
module battery_coulomb_counter_tb;
    import bcc_pkg::*;

    localparam int SPW              = SPW_DEFAULT;
    // Slowest word is a window close plus both sides' longest idle; keep ample margin
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int TAIL_CYCLES      = 300;
    localparam int RANDOM_PER_PHASE = 153;
    localparam int NUM_PHASES       = 8;
    localparam int MAX_IDLE         = 13;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    localparam longint GAUGE_MAS_PER_AH = 3600000;
    localparam longint I32_MAX          = 64'sd2147483647;
    localparam longint I32_MIN          = -64'sd2147483648;
    localparam int     NUM_REGS         = 7;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [NUM_REGS] =
        '{CFG_RSH, CFG_OFS, CFG_CSC, CFG_VSC, CFG_WC, CFG_EFF, CFG_CAP};

    typedef enum {WIN_FULL, WIN_SPARSE, WIN_EMPTY} window_mode_t;

    typedef struct {
        longint current_ma;
        logic   window_done;
        longint avg_shunt_uv;
        longint avg_bus_mv;
        longint avg_current_ma;
        longint charge_mas;
    } gauge_reading_t;

    // Fuel gauge predictor and reading scoreboard
    class gauge_scoreboard;
        longint rsh, ofs, csc, vsc, wc, eff, cap_ah;
        int     win_pos, valid_cnt;
        longint sum_shunt, sum_bus, sum_current, sum_credited;
        longint latest_ma, avg_shunt, avg_bus, avg_current, charge;
        gauge_reading_t expected_readings[$];
        int errors, words_seen, loads_seen, windows_closed, readings_checked;

        function new();
            rsh = 750; ofs = -10; csc = 100; vsc = 1000; wc = 0; eff = 75; cap_ah = 90;
            win_pos = 0; valid_cnt = 0;
            sum_shunt = 0; sum_bus = 0; sum_current = 0; sum_credited = 0;
            latest_ma = 0; avg_shunt = 0; avg_bus = 0; avg_current = 0;
            charge = 90 * GAUGE_MAS_PER_AH;
            errors = 0; words_seen = 0; loads_seen = 0;
            windows_closed = 0; readings_checked = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > I32_MAX) return I32_MAX;
            if (v < I32_MIN) return I32_MIN;
            return v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RSH: rsh = data[RSH_W-1:0];
                CFG_OFS: ofs = longint'(signed'(data[OFS_W-1:0]));
                CFG_CSC: csc = data[CSC_W-1:0];
                CFG_VSC: vsc = data[VSC_W-1:0];
                CFG_WC:  wc = data[WC_W-1:0];
                CFG_EFF: eff = data[EFF_W-1:0];
                CFG_CAP: cap_ah = data[CAP_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the gauge by one accepted word and queue the reading it yields
        function void note_word(logic cmd, longint shunt, longint bus, logic vld, longint ah);
            gauge_reading_t r;
            longint uv, rdiv, ma, mv, credit, cap_mas, n;
            logic done;
            done = 1'b0;
            words_seen++;
            if (cmd == CMD_LOAD) begin
                charge = clamp32(ah * GAUGE_MAS_PER_AH);
                loads_seen++;
            end else begin
                uv = shunt - ofs;
                rdiv = (rsh == 0) ? 1 : rsh;
                ma = clamp32((1000 * uv) / rdiv);
                mv = clamp32((bus * vsc) / 1000);
                ma = clamp32((ma * csc) / 100);
                mv = clamp32(mv - (ma * wc) / 1000);
                credit = (ma >= 0) ? clamp32((ma * eff) / 100) : ma;
                if (vld) begin
                    valid_cnt = (valid_cnt + 1) & 127;
                    sum_shunt = clamp32(sum_shunt + uv);
                    sum_bus = clamp32(sum_bus + mv);
                    sum_current = clamp32(sum_current + ma);
                    sum_credited = clamp32(sum_credited + credit);
                    latest_ma = ma;
                end
                win_pos = (win_pos + 1) & 127;
                if (win_pos >= SPW) begin
                    if (valid_cnt != 0) begin
                        n = valid_cnt;
                        cap_mas = cap_ah * GAUGE_MAS_PER_AH;
                        avg_shunt = clamp32(sum_shunt / n);
                        avg_bus = clamp32(sum_bus / n);
                        avg_current = clamp32(sum_current / n);
                        // Hold the counter while full and still charging
                        if (charge < cap_mas || sum_credited < 0)
                            charge = clamp32(charge + sum_credited / n);
                        done = 1'b1;
                        windows_closed++;
                    end
                    win_pos = 0;
                    valid_cnt = 0;
                    sum_shunt = 0; sum_bus = 0; sum_current = 0; sum_credited = 0;
                end
            end
            r.current_ma = latest_ma;
            r.window_done = done;
            r.avg_shunt_uv = avg_shunt;
            r.avg_bus_mv = avg_bus;
            r.avg_current_ma = avg_current;
            r.charge_mas = charge;
            expected_readings.push_back(r);
        endfunction

        function void compare_field(string name, longint exp_v, longint got_v);
            if (exp_v != got_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_word(gauge_reading_t got);
            gauge_reading_t want;
            if (expected_readings.size() == 0) begin
                $error("reading arrived with none expected");
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            readings_checked++;
            compare_field("current_ma", want.current_ma, got.current_ma);
            compare_field("window_done", want.window_done, got.window_done);
            compare_field("avg_shunt_uv", want.avg_shunt_uv, got.avg_shunt_uv);
            compare_field("avg_bus_mv", want.avg_bus_mv, got.avg_bus_mv);
            compare_field("avg_current_ma", want.avg_current_ma, got.avg_current_ma);
            compare_field("charge_mas", want.charge_mas, got.charge_mas);
        endfunction
    endclass

    logic                        aclk;
    logic                        aresetn        = 1'b0;
    logic                        cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index      = '0;
    logic [CFG_DATA_W-1:0]       cfg_wdata      = '0;
    logic                        s_valid        = 1'b0;
    logic                        s_ready;
    logic                        s_command      = 1'b0;
    logic signed [SHUNT_W-1:0]   s_shunt_uv     = '0;
    logic        [BUS_W-1:0]     s_bus_mv       = '0;
    logic                        s_sample_valid = 1'b0;
    logic        [AH_W-1:0]      s_charge_ah    = '0;
    logic                        m_valid;
    logic                        m_ready        = 1'b0;
    logic signed [DATA_W-1:0]    m_current_ma;
    logic                        m_window_done;
    logic signed [DATA_W-1:0]    m_avg_shunt_uv;
    logic signed [DATA_W-1:0]    m_avg_bus_mv;
    logic signed [DATA_W-1:0]    m_avg_current_ma;
    logic signed [DATA_W-1:0]    m_charge_mas;

    gauge_scoreboard sb = new();
    int              stuck_cycles = 0;
    int              stim_pos = 0;
    window_mode_t    win_mode = WIN_FULL;
    logic            empty_window_sent = 1'b0;
    logic            send_calm = 1'b0;
    logic            recv_calm = 1'b0;
    int              settings_used = 1;

    battery_coulomb_counter dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_shunt_uv       (s_shunt_uv),
        .s_bus_mv         (s_bus_mv),
        .s_sample_valid   (s_sample_valid),
        .s_charge_ah      (s_charge_ah),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_current_ma     (m_current_ma),
        .m_window_done    (m_window_done),
        .m_avg_shunt_uv   (m_avg_shunt_uv),
        .m_avg_bus_mv     (m_avg_bus_mv),
        .m_avg_current_ma (m_avg_current_ma),
        .m_charge_mas     (m_charge_mas)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Offer one word, hold it until accepted, then record it
    task automatic push_word(logic cmd, logic signed [SHUNT_W-1:0] shunt,
                             logic [BUS_W-1:0] bus, logic vld, logic [AH_W-1:0] ah);
        int gap;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_shunt_uv     <= shunt;
        s_bus_mv       <= bus;
        s_sample_valid <= vld;
        s_charge_ah    <= ah;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(cmd, shunt, bus, vld, ah);
        if (cmd == CMD_SAMPLE) stim_pos = (stim_pos + 1) % SPW;
    endtask

    // Build a random word; samples follow a per-window validity pattern
    task automatic push_random_word();
        logic cmd, vld;
        int   sv, bv;
        cmd = ($urandom_range(0, 99) < 4) ? CMD_LOAD : CMD_SAMPLE;
        if (cmd == CMD_SAMPLE && stim_pos == 0) begin
            if (!empty_window_sent) begin
                win_mode = WIN_EMPTY;
                empty_window_sent = 1'b1;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2:    win_mode = WIN_EMPTY;
                    3, 4, 5, 6: win_mode = WIN_SPARSE;
                    default:    win_mode = WIN_FULL;
                endcase
            end
        end
        case ($urandom_range(0, 9))
            0:       sv = $urandom_range(0, 1) ? 524287 : -524288;
            1:       sv = $urandom_range(0, 1) ? 320000 : -320000;
            2, 3, 4: sv = $urandom();
            default: sv = int'($urandom_range(0, 40000)) - 20000;
        endcase
        case ($urandom_range(0, 7))
            0:       bv = 0;
            1:       bv = 32767;
            default: bv = $urandom_range(0, 32767);
        endcase
        case (win_mode)
            WIN_FULL:   vld = ($urandom_range(0, 19) != 0);
            WIN_SPARSE: vld = ($urandom_range(0, 4) == 0);
            default:    vld = 1'b0;
        endcase
        push_word(cmd, SHUNT_W'(sv), BUS_W'(bv), vld, AH_W'($urandom_range(0, 1023)));
    endtask

    // Drop valid and wait until every reading is in, then let the block settle
    task automatic drain_readings(int settle);
        s_valid <= 1'b0;
        while (sb.expected_readings.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic apply_settings(int vals [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_wdata <= CFG_DATA_W'(vals[i]);
            sb.write_reg(REG_ORDER[i], CFG_DATA_W'(vals[i]));
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Result side: random stalls, check each reading as it is taken
    initial begin
        int             stall;
        gauge_reading_t got;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            stall = recv_calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.current_ma     = m_current_ma;
            got.window_done    = m_window_done;
            got.avg_shunt_uv   = m_avg_shunt_uv;
            got.avg_bus_mv     = m_avg_bus_mv;
            got.avg_current_ma = m_avg_current_ma;
            got.charge_mas     = m_charge_mas;
            sb.check_word(got);
        end
    end

    // Stimulus
    initial begin
        int vals [NUM_REGS];
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, an invalid sample, a full window at the cap
        push_word(CMD_SAMPLE, 0, 0, 1'b1, 0);
        push_word(CMD_SAMPLE, 524287, 32767, 1'b1, 1023);
        push_word(CMD_SAMPLE, -524288, 32767, 1'b1, 0);
        push_word(CMD_SAMPLE, 320000, 12000, 1'b0, 0);
        push_word(CMD_SAMPLE, -320000, 0, 1'b1, 0);
        for (int i = 0; i < SPW - 5; i++)
            push_word(CMD_SAMPLE, SHUNT_W'(200000 + $urandom_range(0, 3000)),
                      BUS_W'($urandom_range(11000, 13000)), 1'b1, 0);
        // Counter loads, including one past the 32-bit range
        push_word(CMD_LOAD, -524288, 32767, 1'b1, 0);
        push_word(CMD_LOAD, 524287, 0, 1'b0, 1023);
        push_word(CMD_LOAD, 1000, 5000, 1'b1, 596);
        push_word(CMD_LOAD, 0, 0, 1'b0, 1);
        push_word(CMD_SAMPLE, 150000, 12500, 1'b1, 0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                drain_readings(SETTLE_CYCLES);
                case (p)
                    1: vals = '{100, -1000, 1000, 2000, 1000, 100, 596};
                    2: vals = '{1000000, 1000, 1, 1, 0, 0, 1};
                    3: vals = '{0, -1024, 1023, 2047, 1023, 127, 1023};
                    4: vals = '{1048575, 1023, 0, 0, 0, 0, 0};
                    default: begin
                        vals[0] = $urandom_range(0, 1) ? $urandom_range(100, 3000)
                                                       : $urandom_range(3000, 1000000);
                        vals[1] = int'($urandom_range(0, 2000)) - 1000;
                        vals[2] = $urandom_range(1, 1000);
                        vals[3] = $urandom_range(1, 2000);
                        vals[4] = $urandom_range(0, 1000);
                        vals[5] = $urandom_range(0, 100);
                        vals[6] = $urandom_range(1, 596);
                    end
                endcase
                apply_settings(vals);
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++) push_random_word();
        end

        drain_readings(TAIL_CYCLES);
        $display("Run covered %0d words (%0d counter loads) over %0d register settings.",
                 sb.words_seen, sb.loads_seen, settings_used);
        $display("%0d windows closed with averages; %0d readings checked.",
                 sb.windows_closed, sb.readings_checked);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
